// ===== design/seqt_pkg.sv =====
// Shared types and constants for the sequencer transport.
// Holds request/response payloads, control/status groups and code constants.
// No dependencies.
package seqt_pkg;

	localparam int POS_W      = 32;
	localparam int TPB_W      = 16;
	localparam int TPBAR_W    = 24;
	localparam int SPEED_W    = 16;
	localparam int UNIT_W     = TPB_W + 1;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int DIVD_W     = POS_W + 1;
	localparam int DIVR_W     = TPBAR_W;
	localparam int DIV_STEPS  = (DIVD_W + 1) / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// request function codes
	localparam logic [2:0] FN_ADVANCE  = 3'd0;
	localparam logic [2:0] FN_PLAY     = 3'd1;
	localparam logic [2:0] FN_PAUSE    = 3'd2;
	localparam logic [2:0] FN_STOP     = 3'd3;
	localparam logic [2:0] FN_SET_POS  = 3'd4;
	localparam logic [2:0] FN_NEXT_BAR = 3'd5;
	localparam logic [2:0] FN_QUANTIZE = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TPB       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TPBAR     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SONG_LEN  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_BEG  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID      = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAGS     = 4'd7;

	// quantize grid codes
	localparam logic [2:0] GRID_16TH    = 3'd1;
	localparam logic [2:0] GRID_8TH     = 3'd2;
	localparam logic [2:0] GRID_QUARTER = 3'd3;
	localparam logic [2:0] GRID_HALF    = 3'd4;

	// feature flag bits
	localparam int FLAG_LOOP  = 0;
	localparam int FLAG_METRO = 1;

	// reset values of configuration
	localparam logic [TPB_W-1:0]   RST_TPB   = 16'd96;
	localparam logic [TPBAR_W-1:0] RST_TPBAR = 24'd384;
	localparam logic [SPEED_W-1:0] RST_SPEED = 16'd256;

	typedef struct packed {
		logic [2:0]       func;
		logic [POS_W-1:0] value;
	} seqt_req_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             playing;
		logic             paused;
		logic [POS_W-1:0] quantized;
		logic             beat_click;
		logic             bar_click;
		logic             ended;
	} seqt_rsp_t;

	// divider operand selection
	typedef enum logic [2:0] {
		DS_BEAT,
		DS_BAR,
		DS_NEXT,
		DS_QX,
		DS_QT
	} div_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     load;
		logic     mul;
		logic     sum;
		logic     wrap;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_beat;
		logic     take_bar;
		logic     take_qx;
		logic     commit;
	} seqt_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] func;
		logic       playing;
		logic       metro_ok;
		logic       bar_ok;
		logic       quant_ok;
		logic       ended;
		logic       beat_hit;
		logic       qx_over;
		logic       div_done;
	} seqt_sts_t;

endpackage

// ===== design/seqt_div.sv =====
// Serial remainder unit: two quotient bits per cycle, restoring.
// Depends on seqt_pkg.
module seqt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [seqt_pkg::DIVD_W-1:0]   dividend,
	input  logic [seqt_pkg::DIVR_W-1:0]   divisor,
	output logic                          done,
	output logic [seqt_pkg::DIVR_W-1:0]   rem
);
	import seqt_pkg::*;

	logic [2*DIV_STEPS-1:0] dvd_q;
	logic [DIVR_W-1:0]      rem_q;
	logic [DIVR_W-1:0]      dvr_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [DIVR_W:0]        r1;
	logic [DIVR_W:0]        r2;

	always_comb begin
		r1 = {rem_q, dvd_q[2*DIV_STEPS-1]};
		if (r1 >= {1'b0, dvr_q}) begin
			r1 = r1 - {1'b0, dvr_q};
		end
		r2 = {r1[DIVR_W-1:0], dvd_q[2*DIV_STEPS-2]};
		if (r2 >= {1'b0, dvr_q}) begin
			r2 = r2 - {1'b0, dvr_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= (2*DIV_STEPS)'(dividend);
			rem_q <= '0;
			dvr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[2*DIV_STEPS-3:0], 2'b00};
			rem_q <= r2[DIVR_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== design/seqt_dp.sv =====
// Transport datapath: configuration, playhead state, speed multiply,
// wrap logic, remainder unit and response register. Depends on seqt_pkg, seqt_div.
module seqt_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [seqt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [seqt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  seqt_pkg::seqt_req_t               req,
	input  seqt_pkg::seqt_ctl_t               ctl,
	output seqt_pkg::seqt_sts_t               sts,
	output seqt_pkg::seqt_rsp_t               rsp
);
	import seqt_pkg::*;

	// configuration
	logic [TPB_W-1:0]   tpb_q;
	logic [TPBAR_W-1:0] tpbar_q;
	logic [POS_W-1:0]   song_q;
	logic [POS_W-1:0]   loop_beg_q;
	logic [POS_W-1:0]   loop_end_q;
	logic [SPEED_W-1:0] speed_q;
	logic [2:0]         grid_q;
	logic [1:0]         flags_q;

	// transport state
	logic [POS_W-1:0]   playhead_q;
	logic               playing_q;
	logic               paused_q;

	// per-request work registers
	logic [2:0]               func_q;
	logic [POS_W-1:0]         value_q;
	logic [POS_W+SPEED_W-1:0] prod_s1;
	logic [POS_W-1:0]         sat_q;
	logic [POS_W-1:0]         pos_q;
	logic                     ended_q;
	logic                     beat_q;
	logic                     bar_q;
	logic [POS_W-1:0]         qcand_q;
	logic                     qover_q;
	seqt_rsp_t                rsp_q;

	logic [UNIT_W-1:0]  unit;
	logic [DIVD_W-1:0]  qx_x;
	logic [DIVD_W-1:0]  qdiff;
	logic [DIVD_W-1:0]  next_bar;
	logic [POS_W+SPEED_W-8:0] sum;
	logic [POS_W-1:0]   sat;
	logic [POS_W-1:0]   wrap_pos;
	logic               wrap_end;
	logic               loop_en;
	logic [DIVD_W-1:0]  div_dvd;
	logic [DIVR_W-1:0]  div_dvr;
	logic               div_done;
	logic [DIVR_W-1:0]  div_rem;
	seqt_rsp_t          nxt;

	assign loop_en = flags_q[FLAG_LOOP];

	always_comb begin
		case (grid_q)
			GRID_16TH:    unit = UNIT_W'(tpb_q >> 2);
			GRID_8TH:     unit = UNIT_W'(tpb_q >> 1);
			GRID_QUARTER: unit = UNIT_W'(tpb_q);
			GRID_HALF:    unit = {tpb_q, 1'b0};
			default:      unit = '0;
		endcase
	end

	assign qx_x  = {1'b0, value_q} + DIVD_W'(unit[UNIT_W-1:1]);
	assign qdiff = qx_x - DIVD_W'(div_rem);

	// saturating add of the scaled delta
	assign sum = (POS_W+SPEED_W-7)'(playhead_q) + (POS_W+SPEED_W-7)'(prod_s1[POS_W+SPEED_W-1:8]);
	assign sat = (|sum[POS_W+SPEED_W-8:POS_W]) ? '1 : sum[POS_W-1:0];

	always_comb begin
		wrap_pos = sat_q;
		wrap_end = 1'b0;
		if (loop_en && sat_q >= loop_end_q) begin
			wrap_pos = loop_beg_q;
		end else if (sat_q >= song_q) begin
			if (loop_en) begin
				wrap_pos = loop_beg_q;
			end else begin
				wrap_end = 1'b1;
			end
		end
	end

	always_comb begin
		case (ctl.div_sel)
			DS_BEAT: begin
				div_dvd = DIVD_W'(pos_q);
				div_dvr = DIVR_W'(tpb_q);
			end
			DS_BAR: begin
				div_dvd = DIVD_W'(pos_q);
				div_dvr = tpbar_q;
			end
			DS_NEXT: begin
				div_dvd = DIVD_W'(playhead_q);
				div_dvr = tpbar_q;
			end
			DS_QX: begin
				div_dvd = qx_x;
				div_dvr = DIVR_W'(unit);
			end
			DS_QT: begin
				div_dvd = DIVD_W'(value_q);
				div_dvr = DIVR_W'(unit);
			end
			default: begin
				div_dvd = '0;
				div_dvr = '0;
			end
		endcase
	end

	seqt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvr),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign next_bar = DIVD_W'(playhead_q) - DIVD_W'(div_rem) + DIVD_W'(tpbar_q);

	// resolve the request into the next state and the response
	always_comb begin
		nxt            = '0;
		nxt.position   = playhead_q;
		nxt.playing    = playing_q;
		nxt.paused     = paused_q;
		case (func_q)
			FN_ADVANCE: begin
				if (playing_q) begin
					if (ended_q) begin
						nxt.position = '0;
						nxt.playing  = 1'b0;
						nxt.paused   = 1'b0;
						nxt.ended    = 1'b1;
					end else begin
						nxt.position   = pos_q;
						nxt.beat_click = beat_q;
						nxt.bar_click  = bar_q;
					end
				end
			end
			FN_PLAY: begin
				if (!playing_q) begin
					nxt.playing = 1'b1;
					nxt.paused  = 1'b0;
				end
			end
			FN_PAUSE: begin
				if (playing_q) begin
					nxt.playing = 1'b0;
					nxt.paused  = 1'b1;
				end
			end
			FN_STOP: begin
				nxt.position = '0;
				nxt.playing  = 1'b0;
				nxt.paused   = 1'b0;
			end
			FN_SET_POS: begin
				nxt.position = (value_q > song_q) ? song_q : value_q;
			end
			FN_NEXT_BAR: begin
				if (tpbar_q != '0) begin
					nxt.position = (next_bar > DIVD_W'(song_q)) ? song_q
						: next_bar[POS_W-1:0];
				end
			end
			FN_QUANTIZE: begin
				if (unit == '0) begin
					nxt.quantized = value_q;
				end else if (qover_q) begin
					nxt.quantized = value_q - POS_W'(div_rem);
				end else begin
					nxt.quantized = qcand_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q      <= RST_TPB;
			tpbar_q    <= RST_TPBAR;
			song_q     <= '0;
			loop_beg_q <= '0;
			loop_end_q <= '0;
			speed_q    <= RST_SPEED;
			grid_q     <= '0;
			flags_q    <= '0;
			playhead_q <= '0;
			playing_q  <= 1'b0;
			paused_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TPB:      tpb_q      <= cfg_data[TPB_W-1:0];
					CFG_TPBAR:    tpbar_q    <= cfg_data[TPBAR_W-1:0];
					CFG_SONG_LEN: song_q     <= cfg_data[POS_W-1:0];
					CFG_LOOP_BEG: loop_beg_q <= cfg_data[POS_W-1:0];
					CFG_LOOP_END: loop_end_q <= cfg_data[POS_W-1:0];
					CFG_SPEED:    speed_q    <= cfg_data[SPEED_W-1:0];
					CFG_GRID:     grid_q     <= cfg_data[2:0];
					CFG_FLAGS:    flags_q    <= cfg_data[1:0];
					default: begin
					end
				endcase
			end
			if (ctl.commit) begin
				playhead_q <= nxt.position;
				playing_q  <= nxt.playing;
				paused_q   <= nxt.paused;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			func_q  <= req.func;
			value_q <= req.value;
			ended_q <= 1'b0;
			beat_q  <= 1'b0;
			bar_q   <= 1'b0;
			qover_q <= 1'b0;
		end
		if (ctl.mul) begin
			prod_s1 <= value_q * speed_q;
		end
		if (ctl.sum) begin
			sat_q <= sat;
		end
		if (ctl.wrap) begin
			pos_q   <= wrap_pos;
			ended_q <= wrap_end;
		end
		if (ctl.take_beat) begin
			beat_q <= (div_rem == '0);
		end
		if (ctl.take_bar) begin
			bar_q <= (div_rem == '0);
		end
		if (ctl.take_qx) begin
			qcand_q <= qdiff[POS_W-1:0];
			qover_q <= qdiff[POS_W];
		end
		if (ctl.commit) begin
			rsp_q <= nxt;
		end
	end

	assign sts.func     = func_q;
	assign sts.playing  = playing_q;
	assign sts.metro_ok = flags_q[FLAG_METRO] && (tpb_q != '0);
	assign sts.bar_ok   = (tpbar_q != '0);
	assign sts.quant_ok = (unit != '0);
	assign sts.ended    = ended_q;
	assign sts.beat_hit = (div_rem == '0);
	assign sts.qx_over  = qdiff[POS_W];
	assign sts.div_done = div_done;

	assign rsp = rsp_q;

endmodule

// ===== design/seqt_ctrl.sv =====
// Transport controller: sequences each request through the datapath and
// owns the response valid flag. Depends on seqt_pkg.
module seqt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  seqt_pkg::seqt_sts_t  sts,
	output seqt_pkg::seqt_ctl_t  ctl
);
	import seqt_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_MUL,
		ST_SUM,
		ST_WRAP,
		ST_CHK,
		ST_BEAT_W,
		ST_BAR_W,
		ST_NEXT_W,
		ST_QX_W,
		ST_QT_W,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		ctl     = '0;
		ctl.div_sel = DS_BEAT;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.func)
					FN_ADVANCE: state_d = sts.playing ? ST_MUL : ST_FIN;
					FN_NEXT_BAR: begin
						if (sts.bar_ok) begin
							ctl.div_start = 1'b1;
							ctl.div_sel   = DS_NEXT;
							state_d       = ST_NEXT_W;
						end else begin
							state_d = ST_FIN;
						end
					end
					FN_QUANTIZE: begin
						if (sts.quant_ok) begin
							ctl.div_start = 1'b1;
							ctl.div_sel   = DS_QX;
							state_d       = ST_QX_W;
						end else begin
							state_d = ST_FIN;
						end
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				ctl.sum = 1'b1;
				state_d = ST_WRAP;
			end
			ST_WRAP: begin
				ctl.wrap = 1'b1;
				state_d  = ST_CHK;
			end
			ST_CHK: begin
				if (!sts.ended && sts.metro_ok) begin
					ctl.div_start = 1'b1;
					ctl.div_sel   = DS_BEAT;
					state_d       = ST_BEAT_W;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_BEAT_W: begin
				if (sts.div_done) begin
					ctl.take_beat = 1'b1;
					if (sts.beat_hit && sts.bar_ok) begin
						ctl.div_start = 1'b1;
						ctl.div_sel   = DS_BAR;
						state_d       = ST_BAR_W;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_BAR_W: begin
				ctl.div_sel = DS_BAR;
				if (sts.div_done) begin
					ctl.take_bar = 1'b1;
					state_d      = ST_FIN;
				end
			end
			ST_NEXT_W: begin
				if (sts.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_QX_W: begin
				ctl.div_sel = DS_QX;
				if (sts.div_done) begin
					ctl.take_qx = 1'b1;
					if (sts.qx_over) begin
						ctl.div_start = 1'b1;
						ctl.div_sel   = DS_QT;
						state_d       = ST_QT_W;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_QT_W: begin
				if (sts.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== design/sequencer_transport.sv =====
// Top level of the music sequencer transport.
// Joins seqt_ctrl and seqt_dp; depends on seqt_pkg.
//
// Usage:
//   req (func, value) arrives on a valid/ready channel; rsp (position, flags,
//   quantized tick, clicks, ended) leaves on another, one response per request.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); indexes
//   beyond the register list are ignored. Write it only while the block is idle.
// Sequencing (accept to rsp_valid):
//   play, pause, stop, set position, unused code: dispatch, then commit.
//   next bar: one remainder pass; quantize: one pass, or a second one when rounding
//   up overflows and the tick is rounded down instead.
//   advance: multiply, sum and wrap, plus the metronome's beat and bar checks.
//   Throughput is one request at a time; the next request is taken the cycle
//   after the commit. The serial remainder unit, two bits a cycle, sets the
//   long cases.
// Stall: a finished response sits in the output register while the next
//   request is taken in and worked on; that one waits for the slot to free.
// Reset: arst_n clears playhead and flags, restores default configuration.
module sequencer_transport (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  seqt_pkg::seqt_req_t               req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output seqt_pkg::seqt_rsp_t               rsp,
	input  logic                              cfg_we,
	input  logic [seqt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [seqt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import seqt_pkg::*;

	seqt_ctl_t ctl;
	seqt_sts_t sts;

	// sequence each request: dispatch, multiply, wrap, remainder passes, commit
	seqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// hold configuration, transport state and the response register
	seqt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.ctl       (ctl),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
